@@ rtl/tskl_pkg.sv @@
`default_nettype none

package tskl_pkg;

    localparam int MAX_STRING_LEN = 1024;
    localparam int NAME_BYTES     = 8;
    localparam int IDX_W          = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 64;

    localparam logic [7:0] CH_TICK  = 8'h27;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BLANK = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_NAME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LEN  = 2'd2;

    localparam logic [1:0] STATUS_FOUND    = 2'd0;
    localparam logic [1:0] STATUS_ABSENT   = 2'd1;
    localparam logic [1:0] STATUS_ZERO_LEN = 2'd2;

    localparam logic signed [11:0] TD_MAX = 12'sh7FF;
    localparam logic signed [11:0] TD_MIN = -12'sh800;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_NAME  = 2'd1,
        PH_VALUE = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [IDX_W-1:0]   char_index;
        logic [7:0]         prev_char;
        logic [IDX_W-1:0]   name_offset;
        logic               name_match;
        logic               match_found;
        logic signed [11:0] tick_depth;
        logic               value_begun;
        logic               ticked_value;
        logic [IDX_W-1:0]   name_start;
        logic [IDX_W-1:0]   name_end;
        logic [IDX_W-1:0]   value_start;
        logic [IDX_W-1:0]   value_end;
    } scan_state_t;

    typedef struct packed {
        logic [IDX_W-1:0] max_len;
        logic [63:0]      search_name;
        logic [3:0]       search_len;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] name_start;
        logic [IDX_W-1:0] name_end;
        logic [IDX_W-1:0] value_start;
        logic [IDX_W-1:0] value_end;
        logic             has_ticks;
    } result_t;

    function automatic scan_state_t scan_reset();
        scan_state_t s;
        s       = '0;
        s.phase = PH_IDLE;
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/tskl_step.sv @@
`default_nettype none

module tskl_step (
    input  tskl_pkg::scan_state_t state_in,
    input  logic [7:0]            char_code,
    input  tskl_pkg::cfg_t        cfg,
    output tskl_pkg::scan_state_t state_next,
    output logic                  emit,
    output tskl_pkg::result_t     result
);
    import tskl_pkg::*;

    localparam logic [IDX_W-1:0] LIMIT_CAP = IDX_W'(MAX_STRING_LEN);

    function automatic logic byte_matches(input logic [IDX_W-1:0] offset,
                                          input logic [7:0] c,
                                          input cfg_t cf);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NAME_BYTES; i++) begin
            if (offset == IDX_W'(i) && offset < {{(IDX_W-4){1'b0}}, cf.search_len} &&
                cf.search_name[8*i +: 8] == c) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    always_comb begin
        scan_state_t      s;
        logic [7:0]       c;
        logic [IDX_W-1:0] limit;
        logic             at_end;
        logic             ended_now;
        logic [IDX_W-1:0] vs;
        logic [IDX_W-1:0] ve;

        s         = state_in;
        ended_now = 1'b0;
        emit      = 1'b0;
        result    = '0;
        c         = char_code;
        limit     = (cfg.max_len < LIMIT_CAP) ? cfg.max_len : LIMIT_CAP;
        at_end    = 1'b0;
        vs        = '0;
        ve        = '0;

        if (cfg.max_len == '0) begin
            emit          = 1'b1;
            result.status = STATUS_ZERO_LEN;
            s             = scan_reset();
        end else begin
            // at or past the limit the character counts as the terminator
            if (state_in.char_index >= limit) begin
                c = CH_NUL;
            end
            at_end = (c == CH_NUL);

            unique case (state_in.phase)
                PH_IDLE: begin
                    if (c != CH_BLANK) begin
                        s.value_start  = '0;
                        s.value_end    = '0;
                        s.name_end     = '0;
                        s.value_begun  = 1'b0;
                        s.ticked_value = 1'b0;
                        s.phase        = PH_NAME;
                        s.name_start   = state_in.char_index;
                        s.name_offset  = IDX_W'(1);
                        s.name_match   = byte_matches('0, c, cfg);
                    end
                end
                PH_NAME: begin
                    if (at_end || c == CH_EQ) begin
                        s.phase      = PH_VALUE;
                        s.tick_depth = '0;
                        if (state_in.name_match &&
                            state_in.name_offset == {{(IDX_W-4){1'b0}}, cfg.search_len}) begin
                            s.name_end    = state_in.char_index;
                            s.match_found = 1'b1;
                        end
                    end else if (c == CH_BLANK) begin
                        s.phase        = PH_IDLE;
                        s.name_start   = '0;
                        s.name_end     = '0;
                        s.value_start  = '0;
                        s.value_end    = '0;
                        s.value_begun  = 1'b0;
                        s.ticked_value = 1'b0;
                    end else begin
                        s.name_match = state_in.name_match &&
                                       byte_matches(state_in.name_offset, c, cfg);
                        if (state_in.name_offset != '1) begin
                            s.name_offset = state_in.name_offset + IDX_W'(1);
                        end
                    end
                end
                default: begin
                    // a tick right after '=' opens a level, any other closes one
                    if (c == CH_TICK) begin
                        if (state_in.prev_char == CH_EQ) begin
                            if (state_in.tick_depth != TD_MAX) begin
                                s.tick_depth = state_in.tick_depth + 12'sd1;
                            end
                        end else if (state_in.tick_depth != TD_MIN) begin
                            s.tick_depth = state_in.tick_depth - 12'sd1;
                        end
                    end
                    if (!state_in.value_begun) begin
                        if (c == CH_TICK) begin
                            s.ticked_value = 1'b1;
                        end else begin
                            s.value_start = state_in.char_index;
                            s.value_begun = 1'b1;
                        end
                    end else if (at_end ||
                                 (state_in.ticked_value && s.tick_depth <= 12'sd0) ||
                                 (!state_in.ticked_value && c == CH_BLANK)) begin
                        s.value_end = state_in.char_index;
                        ended_now   = 1'b1;
                        s.phase     = PH_IDLE;
                    end
                end
            endcase

            emit = at_end || (s.match_found && s.phase == PH_IDLE);

            if (!emit) begin
                s.prev_char  = c;
                s.char_index = state_in.char_index + IDX_W'(1);
            end else begin
                if (s.match_found) begin
                    vs                 = s.value_begun ? s.value_start : state_in.char_index;
                    ve                 = ended_now ? s.value_end : vs;
                    result.status      = STATUS_FOUND;
                    result.name_start  = s.name_start;
                    result.name_end    = s.name_end;
                    result.value_start = vs;
                    result.value_end   = ve;
                    result.has_ticks   = s.ticked_value;
                end else begin
                    result.status = STATUS_ABSENT;
                end
                s = scan_reset();
            end
        end

        state_next = s;
    end

endmodule

`default_nettype wire

@@ rtl/tskl_out_queue.sv @@
`default_nettype none

module tskl_out_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tskl_pkg::result_t push_data,
    input  logic              m_ready,
    output logic              m_valid,
    output tskl_pkg::result_t m_data,
    output logic              skid_full
);
    import tskl_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop       = out_valid_reg && m_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign skid_full = skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (pop) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (push) begin
                if (!out_valid_reg || pop) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    // hold the new beat until the output register drains
                    skid_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_reg <= push_data;
            end else begin
                skid_data_reg <= push_data;
            end
        end
    end

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output register is empty");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !skid_valid_reg)
        else $error("result pushed while skid stage is occupied");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid beat not moved to output register");

endmodule

`default_nettype wire

@@ rtl/tuple_string_key_locator.sv @@
`default_nettype none

// Channel   Direction  Payload                                          Beat when
// s_        in         char_code                                        s_valid && s_ready
// m_        out        status, name/value start and end, has_ticks      m_valid && m_ready
// cfg_      in         cfg_index, cfg_wdata                             cfg_wr_en
//
// One character beat per cycle sustained while the skid stage is not full; a beat
// sits in the input register while its scan step runs, and its result (if any) is
// loaded into the output register, or into the skid stage while that is occupied.
// The output register plus a skid stage let input continue while a result waits.
// Input stalls only when the skid stage is full. Reset is synchronous: the scan
// restarts at index zero, max_len returns to 1024 and the search name is cleared.

module tuple_string_key_locator (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_char_code,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [1:0]                          m_status,
    output logic [tskl_pkg::IDX_W-1:0]          m_name_start,
    output logic [tskl_pkg::IDX_W-1:0]          m_name_end,
    output logic [tskl_pkg::IDX_W-1:0]          m_value_start,
    output logic [tskl_pkg::IDX_W-1:0]          m_value_end,
    output logic                                m_has_ticks,
    input  wire logic                           cfg_wr_en,
    input  wire logic [tskl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tskl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tskl_pkg::*;

    cfg_t        cfg_reg;
    scan_state_t state_reg;
    scan_state_t state_next;
    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        advance;
    logic        step_emit;
    result_t     step_result;
    logic        skid_full;
    result_t     m_data;

    assign advance = in_valid_reg && !skid_full;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_len     <= IDX_W'(1024);
            cfg_reg.search_name <= '0;
            cfg_reg.search_len  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MAX_LEN:     cfg_reg.max_len     <= cfg_wdata[IDX_W-1:0];
                CFG_SEARCH_NAME: cfg_reg.search_name <= cfg_wdata[63:0];
                CFG_SEARCH_LEN:  cfg_reg.search_len  <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scan_reset();
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    tskl_step u_step (
        .state_in   (state_reg),
        .char_code  (in_char_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    tskl_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (advance && step_emit),
        .push_data (step_result),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .skid_full (skid_full)
    );

    assign m_status      = m_data.status;
    assign m_name_start  = m_data.name_start;
    assign m_name_end    = m_data.name_end;
    assign m_value_start = m_data.value_start;
    assign m_value_end   = m_data.value_end;
    assign m_has_ticks   = m_data.has_ticks;

    a_emit_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && step_emit) |=> (state_reg.char_index == '0 && state_reg.phase == PH_IDLE))
        else $error("scan did not restart after a result");

    a_miss_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STATUS_FOUND) |->
        (m_name_start == '0 && m_name_end == '0 && m_value_start == '0 &&
         m_value_end == '0 && !m_has_ticks))
        else $error("non-found result carries span data");

    a_index_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.char_index <= IDX_W'(MAX_STRING_LEN))
        else $error("character index ran past the string limit");

endmodule

`default_nettype wire

@@ dv/tb_tuple_string_key_locator.sv @@
`timescale 1ns / 1ps

module tb_tuple_string_key_locator;
    import tskl_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          LONG_HOLD     = 400;
    localparam int          MAX_REPORTS   = 10;
    localparam int          PHASES        = 12;
    localparam logic [7:0]  CH_LOWER_A    = 8'h61;

    localparam result_t ABSENT_RES   = '{STATUS_ABSENT, 11'd0, 11'd0, 11'd0, 11'd0, 1'b0};
    localparam result_t ZERO_LEN_RES = '{STATUS_ZERO_LEN, 11'd0, 11'd0, 11'd0, 11'd0, 1'b0};

    typedef struct {
        bit          is_write;
        logic [1:0]  sel;
        logic [63:0] wdata;
        logic [7:0]  ch;
        bit          typed;
        result_t     res;
    } stim_row_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_char_code = 8'h00;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [1:0]            m_status;
    logic [IDX_W-1:0]      m_name_start;
    logic [IDX_W-1:0]      m_name_end;
    logic [IDX_W-1:0]      m_value_start;
    logic [IDX_W-1:0]      m_value_end;
    logic                  m_has_ticks;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

    // register copies
    logic [IDX_W-1:0] len_cap;
    logic [63:0]      key_name;
    logic [3:0]       key_len;

    // scan state
    phase_t             scan_ph;
    logic [IDX_W-1:0]   scan_idx;
    logic [7:0]         prev_ch;
    logic [IDX_W-1:0]   name_off;
    logic               name_ok;
    logic               key_hit;
    logic signed [11:0] depth;
    logic               val_begun;
    logic               val_ticked;
    logic [IDX_W-1:0]   span_ns, span_ne, span_vs, span_ve;

    result_t     locator_results_q[$];
    stim_row_t   directed_rows[$];
    logic [7:0]  pending_chars[$];
    int unsigned fault_count = 0;
    int unsigned cycle_count = 0;
    bit          send_burst  = 1'b0;
    bit          recv_burst  = 1'b0;
    bit          hold_request = 1'b0;

    tuple_string_key_locator u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_name_start  (m_name_start),
        .m_name_end    (m_name_end),
        .m_value_start (m_value_start),
        .m_value_end   (m_value_end),
        .m_has_ticks   (m_has_ticks),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void drop_tuple();
        span_ns    = '0;
        span_ne    = '0;
        span_vs    = '0;
        span_ve    = '0;
        val_begun  = 1'b0;
        val_ticked = 1'b0;
    endfunction

    function automatic void clear_scan();
        drop_tuple();
        scan_ph  = PH_IDLE;
        scan_idx = '0;
        prev_ch  = '0;
        name_off = '0;
        name_ok  = 1'b0;
        key_hit  = 1'b0;
        depth    = '0;
    endfunction

    function automatic bit key_byte_ok(logic [IDX_W-1:0] off, logic [7:0] ch);
        if (off >= key_len || off >= NAME_BYTES)
            return 1'b0;
        return key_name[8*off +: 8] == ch;
    endfunction

    // Advance the scan by one character; return 1 when a location result is due.
    function automatic bit locate_step(input logic [7:0] ch_in, output result_t res);
        logic [7:0]       c;
        logic [IDX_W-1:0] lim;
        logic [IDX_W-1:0] vs, ve;
        bit               at_end;
        bit               ended_now;
        res = '0;
        ended_now = 1'b0;
        if (len_cap == '0) begin
            res = ZERO_LEN_RES;
            clear_scan();
            return 1'b1;
        end
        lim = (len_cap < MAX_STRING_LEN) ? len_cap : IDX_W'(MAX_STRING_LEN);
        c = (scan_idx >= lim) ? CH_NUL : ch_in;
        at_end = (c == CH_NUL);

        case (scan_ph)
            PH_IDLE: begin
                if (c != CH_BLANK) begin
                    drop_tuple();
                    scan_ph  = PH_NAME;
                    span_ns  = scan_idx;
                    name_off = IDX_W'(1);
                    name_ok  = key_byte_ok('0, c);
                end
            end
            PH_NAME: begin
                if (at_end || c == CH_EQ) begin
                    scan_ph = PH_VALUE;
                    depth   = '0;
                    if (name_ok && name_off == key_len) begin
                        span_ne = scan_idx;
                        key_hit = 1'b1;
                    end
                end else if (c == CH_BLANK) begin
                    scan_ph = PH_IDLE;
                    drop_tuple();
                end else begin
                    name_ok = name_ok && key_byte_ok(name_off, c);
                    if (name_off < 11'h7FF)
                        name_off = name_off + IDX_W'(1);
                end
            end
            default: begin
                // a tick right after '=' opens a level, any other closes one
                if (c == CH_TICK) begin
                    if (prev_ch == CH_EQ) begin
                        if (depth < TD_MAX)
                            depth = depth + 12'sd1;
                    end else if (depth > TD_MIN) begin
                        depth = depth - 12'sd1;
                    end
                end
                if (!val_begun) begin
                    if (c == CH_TICK) begin
                        val_ticked = 1'b1;
                    end else begin
                        span_vs   = scan_idx;
                        val_begun = 1'b1;
                    end
                end else if (at_end || (val_ticked && depth <= 12'sd0) ||
                             (!val_ticked && c == CH_BLANK)) begin
                    span_ve   = scan_idx;
                    ended_now = 1'b1;
                    scan_ph   = PH_IDLE;
                end
            end
        endcase

        if (!(at_end || (key_hit && scan_ph == PH_IDLE))) begin
            prev_ch  = c;
            scan_idx = scan_idx + IDX_W'(1);
            return 1'b0;
        end

        if (key_hit) begin
            vs  = val_begun ? span_vs : scan_idx;
            ve  = ended_now ? span_ve : vs;
            res = '{STATUS_FOUND, span_ns, span_ne, vs, ve, val_ticked};
        end else begin
            res = ABSENT_RES;
        end
        clear_scan();
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(0, 15) == 0)
            return 8'($urandom_range(128, 255));
        return CH_LOWER_A + 8'($urandom_range(0, 3));
    endfunction

    // Build one tuple string, mostly well formed, into pending_chars.
    function automatic void compose_string();
        int ntup, n, k, lvl;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 20);
            repeat (n) pending_chars.push_back(8'($urandom_range(0, 255)));
            pending_chars.push_back(CH_NUL);
            return;
        end
        ntup = $urandom_range(1, 4);
        repeat (ntup) begin
            repeat ($urandom_range(0, 2)) pending_chars.push_back(CH_BLANK);
            if ($urandom_range(0, 1) == 1 && key_len != 0 && key_len <= NAME_BYTES) begin
                n = int'(key_len);
                if ($urandom_range(0, 5) == 0 && n > 1)
                    n = n - 1;
                for (k = 0; k < n; k++)
                    pending_chars.push_back(key_name[8*k +: 8]);
                if ($urandom_range(0, 5) == 0)
                    pending_chars.push_back(pick_letter());
            end else begin
                n = $urandom_range(1, 5);
                repeat (n) pending_chars.push_back(pick_letter());
            end
            if ($urandom_range(0, 7) != 0) begin
                pending_chars.push_back(CH_EQ);
                case ($urandom_range(0, 3))
                    0: begin
                        repeat ($urandom_range(0, 4)) pending_chars.push_back(pick_letter());
                    end
                    1, 2: begin
                        pending_chars.push_back(CH_TICK);
                        lvl = 1;
                        repeat ($urandom_range(0, 6)) begin
                            case ($urandom_range(0, 3))
                                0: pending_chars.push_back(CH_BLANK);
                                1: begin
                                    // nest one level deeper
                                    pending_chars.push_back(CH_EQ);
                                    pending_chars.push_back(CH_TICK);
                                    lvl++;
                                end
                                2: begin
                                    if (lvl > 1) begin
                                        pending_chars.push_back(CH_TICK);
                                        lvl--;
                                    end else begin
                                        pending_chars.push_back(pick_letter());
                                    end
                                end
                                default: pending_chars.push_back(pick_letter());
                            endcase
                        end
                        // leave some values unterminated
                        if ($urandom_range(0, 5) != 0)
                            repeat (lvl) pending_chars.push_back(CH_TICK);
                    end
                    default: begin
                        pending_chars.push_back(8'($urandom_range(1, 255)));
                        repeat ($urandom_range(0, 3)) pending_chars.push_back(pick_letter());
                    end
                endcase
            end
            if ($urandom_range(0, 4) != 0)
                pending_chars.push_back(CH_BLANK);
        end
        if ($urandom_range(0, 3) != 0)
            pending_chars.push_back(CH_NUL);
    endfunction

    function automatic void add_char(logic [7:0] ch, bit typed, result_t res);
        stim_row_t r;
        r.is_write = 1'b0;
        r.sel      = '0;
        r.wdata    = '0;
        r.ch       = ch;
        r.typed    = typed;
        r.res      = res;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], 1'b0, '0);
    endfunction

    function automatic void add_write(logic [1:0] sel, logic [63:0] data);
        stim_row_t r;
        r.is_write = 1'b1;
        r.sel      = sel;
        r.wdata    = data;
        r.ch       = '0;
        r.typed    = 1'b0;
        r.res      = '0;
        directed_rows.push_back(r);
    endfunction

    task automatic offer_char(input logic [7:0] ch, input bit typed, input result_t typed_res);
        int      gap;
        result_t res;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= ch;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (locate_step(ch, res))
            locator_results_q.push_back(typed ? typed_res : res);
        else if (typed)
            locator_results_q.push_back(typed_res);
    endtask

    // Drop valid, drain the results, then let the pipeline settle.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (locator_results_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] sel, input logic [63:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= data;
        @(posedge aclk);
        case (sel)
            CFG_MAX_LEN:     len_cap  = data[IDX_W-1:0];
            CFG_SEARCH_NAME: key_name = data;
            CFG_SEARCH_LEN:  key_len  = data[3:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        result_t seen, want;
        if (aresetn && m_valid && m_ready) begin
            seen = '{m_status, m_name_start, m_name_end, m_value_start, m_value_end,
                     m_has_ticks};
            if (locator_results_q.size() == 0) begin
                if (fault_count < MAX_REPORTS)
                    $display("unexpected result beat: status %0d ns %0d ne %0d vs %0d ve %0d t %0d",
                             seen.status, seen.name_start, seen.name_end,
                             seen.value_start, seen.value_end, seen.has_ticks);
                fault_count++;
            end else begin
                want = locator_results_q.pop_front();
                if (seen.status !== want.status || seen.name_start !== want.name_start ||
                    seen.name_end !== want.name_end ||
                    seen.value_start !== want.value_start ||
                    seen.value_end !== want.value_end ||
                    seen.has_ticks !== want.has_ticks) begin
                    if (fault_count < MAX_REPORTS)
                        $display("result mismatch: exp %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
                                 want.status, want.name_start, want.name_end,
                                 want.value_start, want.value_end, want.has_ticks,
                                 seen.status, seen.name_start, seen.name_end,
                                 seen.value_start, seen.value_end, seen.has_ticks);
                    fault_count++;
                end
            end
        end
    end

    // Result side: random stalls per beat, one long hold on request.
    initial begin
        int stall;
        wait (aresetn);
        m_ready <= 1'b1;
        forever begin
            do @(posedge aclk); while (!(m_valid && m_ready));
            if (hold_request) begin
                stall        = LONG_HOLD;
                hold_request = 1'b0;
            end else begin
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
                stall = recv_burst ? 0 : $urandom_range(0, 14);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [IDX_W-1:0] new_cap;
        logic [63:0]      new_name;
        logic [3:0]       new_len;
        int               quota, sent, k;

        len_cap  = 11'd1024;
        key_name = '0;
        key_len  = '0;
        clear_scan();

        add_char(CH_NUL, 1'b1, ABSENT_RES);
        add_write(CFG_SEARCH_NAME, 64'h6261);
        add_write(CFG_SEARCH_LEN, 64'd2);
        add_text("ab='x y'");
        add_text("==");
        add_char(CH_NUL, 1'b1, ABSENT_RES);
        add_text("ab");
        add_char(CH_NUL, 1'b0, '0);
        add_write(CFG_MAX_LEN, 64'd5);
        add_text("ab=");
        add_char(8'hFF, 1'b0, '0);
        add_char("q", 1'b0, '0);
        add_write(CFG_MAX_LEN, 64'd0);
        add_char("x", 1'b1, ZERO_LEN_RES);
        add_write(CFG_MAX_LEN, 64'd2047);
        add_write(CFG_SEARCH_NAME, '1);
        add_write(CFG_SEARCH_LEN, 64'd15);
        add_char(8'hFF, 1'b0, '0);
        add_char(CH_NUL, 1'b1, ABSENT_RES);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_write) begin
                wait_quiet();
                write_reg(directed_rows[i].sel, directed_rows[i].wdata);
            end else begin
                offer_char(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].res);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_quiet();
            case (ph)
                1:       new_cap = 11'd0;
                2:       new_cap = 11'd2047;
                3:       new_cap = 11'd1024;
                default: begin
                    case ($urandom_range(0, 4))
                        0:       new_cap = 11'd1024;
                        1:       new_cap = 11'($urandom_range(1, 12));
                        2:       new_cap = 11'($urandom_range(13, 60));
                        3:       new_cap = 11'($urandom_range(1, 2047));
                        default: new_cap = 11'($urandom_range(61, 1023));
                    endcase
                end
            endcase
            case ($urandom_range(0, 9))
                0:       new_len = 4'd0;
                1:       new_len = 4'($urandom_range(9, 15));
                default: new_len = 4'($urandom_range(1, 8));
            endcase
            if ($urandom_range(0, 4) == 0) begin
                new_name = {$urandom, $urandom};
            end else begin
                for (k = 0; k < 8; k++)
                    new_name[8*k +: 8] = CH_LOWER_A + 8'($urandom_range(0, 3));
                if ($urandom_range(0, 7) == 0)
                    new_name[8*$urandom_range(0, 7) +: 8] = CH_NUL;
            end
            // starve the result side while every beat yields a result
            if (ph == 1)
                hold_request = 1'b1;
            write_reg(CFG_MAX_LEN, 64'(new_cap));
            write_reg(CFG_SEARCH_NAME, new_name);
            write_reg(CFG_SEARCH_LEN, 64'(new_len));

            quota = (ph == 1) ? 60 : 130;
            sent  = 0;
            while (sent < quota) begin
                pending_chars.delete();
                compose_string();
                while (pending_chars.size() != 0) begin
                    offer_char(pending_chars.pop_front(), 1'b0, '0);
                    sent++;
                end
            end
            // close the string so the next settings start a fresh scan
            offer_char(CH_NUL, 1'b0, '0);
        end

        wait_quiet();
        if (fault_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
